@@ src/grib1_rhp_pkg.sv @@
// Shared types, constants and helper functions of the GRIB edition 1 record header parser.
package grib1_rhp_pkg;

    // Default parameter values
    localparam int HEADER_BYTES_DEF = 21;
    localparam int COUNTER_BITS_DEF = 16;

    // Number of product definition bytes that feed the result
    localparam int PDS_USED = 21;

    // Indicator section layout
    localparam logic [23:0] POS_LEN_FIRST = 24'd4;
    localparam logic [23:0] POS_LEN_LAST  = 24'd6;
    localparam logic [23:0] POS_EDITION   = 24'd7;
    localparam logic [23:0] POS_PDS       = 24'd8;

    // Record framing
    localparam logic [31:0] TAG_WORD     = 32'h4752_4942;  // "GRIB"
    localparam logic [31:0] TRAILER_WORD = 32'h3737_3737;  // "7777"
    localparam logic [23:0] MIN_RECORD   = 24'd12;

    // Forecast time unit codes
    localparam logic [7:0] UNIT_MINUTE = 8'd0;
    localparam logic [7:0] UNIT_HOUR   = 8'd1;
    localparam logic [7:0] UNIT_DAY    = 8'd2;
    localparam logic [7:0] UNIT_SECOND = 8'd254;

    localparam logic [16:0] SEC_PER_MINUTE = 17'd60;
    localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
    localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
    localparam logic [16:0] SEC_PER_SECOND = 17'd1;

    // Time range indicator codes
    localparam logic [7:0] TRI_VALID_AT_P1  = 8'd0;
    localparam logic [7:0] TRI_INITIALIZED  = 8'd1;
    localparam logic [7:0] TRI_PERIOD_P1_P2 = 8'd2;
    localparam logic [7:0] TRI_AVERAGE      = 8'd3;
    localparam logic [7:0] TRI_ACCUMULATION = 8'd4;
    localparam logic [7:0] TRI_DIFFERENCE   = 8'd5;

    // Level indicator codes
    localparam logic [7:0] LEVEL_ISOBARIC = 8'd100;
    localparam logic [7:0] LEVEL_MSL_ALT  = 8'd103;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_TAG     = 3'd1,
        ST_BAD_TRAILER = 3'd2,
        ST_TRUNCATED   = 3'd3,
        ST_BAD_LENGTH  = 3'd4
    } t_status;

    typedef struct packed {
        logic [15:0] record_number;
        logic [7:0]  year_of_century;
        logic [7:0]  month_value;
        logic [7:0]  day_value;
        logic [7:0]  hour_value;
        logic [7:0]  minute_value;
        logic [7:0]  grid_number;
        logic [7:0]  field_number;
        logic [24:0] offset_seconds;
        logic [7:0]  level_type;
        logic [15:0] level_value;
        t_status     status;
    } t_result;

    // Expected tag byte at a given indicator position
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = TAG_WORD[31:24];
            2'd1:    v = TAG_WORD[23:16];
            2'd2:    v = TAG_WORD[15:8];
            default: v = TAG_WORD[7:0];
        endcase
        return v;
    endfunction

    // Forecast offset in seconds from unit, P1, P2 and time range indicator
    function automatic logic [24:0] forecast_offset(
        input logic [7:0] unit,
        input logic [7:0] p1,
        input logic [7:0] p2,
        input logic [7:0] range_ind
    );
        logic [16:0] mult;
        logic        unit_ok;
        logic [7:0]  period;
        logic        range_ok;
        mult    = SEC_PER_SECOND;
        unit_ok = 1'b1;
        case (unit)
            UNIT_MINUTE: mult = SEC_PER_MINUTE;
            UNIT_HOUR:   mult = SEC_PER_HOUR;
            UNIT_DAY:    mult = SEC_PER_DAY;
            UNIT_SECOND: mult = SEC_PER_SECOND;
            default:     unit_ok = 1'b0;
        endcase
        period   = p1;
        range_ok = 1'b1;
        case (range_ind)
            TRI_VALID_AT_P1, TRI_PERIOD_P1_P2, TRI_AVERAGE: period = p1;
            TRI_ACCUMULATION, TRI_DIFFERENCE:               period = p2;
            default:                                        range_ok = 1'b0;
        endcase
        if (!(unit_ok && range_ok)) begin
            return 25'd0;
        end
        return 25'(mult) * 25'(period);
    endfunction

endpackage

@@ src/grib1_rhp_if.sv @@
// Valid/ready channel interfaces for the byte stream and the record results.
interface grib1_rhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface grib1_rhp_result_if;
    logic                  valid;
    logic                  ready;
    logic [15:0]           record_number;
    logic [7:0]            year_of_century;
    logic [7:0]            month_value;
    logic [7:0]            day_value;
    logic [7:0]            hour_value;
    logic [7:0]            minute_value;
    logic [7:0]            grid_number;
    logic [7:0]            field_number;
    logic [24:0]           offset_seconds;
    logic [7:0]            level_type;
    logic [15:0]           level_value;
    grib1_rhp_pkg::t_status status;

    modport source (
        output valid, output record_number, output year_of_century, output month_value,
        output day_value, output hour_value, output minute_value, output grid_number,
        output field_number, output offset_seconds, output level_type,
        output level_value, output status, input ready
    );
    modport sink (
        input valid, input record_number, input year_of_century, input month_value,
        input day_value, input hour_value, input minute_value, input grid_number,
        input field_number, input offset_seconds, input level_type,
        input level_value, input status, output ready
    );
endinterface

@@ src/grib1_rhp_skid.sv @@
// Output register plus skid stage that decouples result delivery from byte intake.
module grib1_rhp_skid (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  grib1_rhp_pkg::t_result i_result,
    output logic                   o_ready,
    grib1_rhp_result_if.source     o_result_if
);
    import grib1_rhp_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_out_valid && o_result_if.ready;
    assign o_ready = !r_skid_valid;

    // Refill the output register from skid first, then from a new push
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_push;
                n_skid       = i_result;
            end else begin
                n_out_valid = i_push;
                n_out       = i_result;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_result;
        end
    end

    // Hold control flags under reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_result_if.valid           = r_out_valid;
    assign o_result_if.record_number   = r_out.record_number;
    assign o_result_if.year_of_century = r_out.year_of_century;
    assign o_result_if.month_value     = r_out.month_value;
    assign o_result_if.day_value       = r_out.day_value;
    assign o_result_if.hour_value      = r_out.hour_value;
    assign o_result_if.minute_value    = r_out.minute_value;
    assign o_result_if.grid_number     = r_out.grid_number;
    assign o_result_if.field_number    = r_out.field_number;
    assign o_result_if.offset_seconds  = r_out.offset_seconds;
    assign o_result_if.level_type      = r_out.level_type;
    assign o_result_if.level_value     = r_out.level_value;
    assign o_result_if.status          = r_out.status;

    // A push never lands on a full skid stage
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed while skid stage full");

    // The skid stage is only occupied behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result with output register empty");

    // A stalled output with nothing pushed keeps the skid occupancy unchanged
    a_stall_keeps_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result_if.ready && !i_push) |=> $stable(r_skid_valid))
        else $error("skid occupancy changed during a stall without a push");

endmodule

@@ src/grib1_record_header_parser_unit.sv @@
// Top level of the GRIB edition 1 record header parser: byte intake, field capture, checks.
//
// Usage:
//   i_byte_if carries the file one byte per transaction, with final_byte set on the
//   last byte of the file. o_result_if carries one result per record end, and one
//   per error (bad tag, bad length, bad trailer, truncated record).
//   Throughput: one byte per cycle while ready is high. Each byte is parsed in the
//   cycle it is accepted; all counters and captured fields sit in registers updated
//   at that edge. A result enters the output register, or the skid stage if that is full.
//   Stall: results wait in an output register backed by a one-entry skid stage, so
//   bytes keep flowing while one result waits; ready drops only when both hold a
//   result, and rises again the cycle after the receiver takes one.
//   Reset (i_rst_n low, synchronous): clears position, lengths, captured header,
//   trailer window, record counter and the halt flag; pending results are dropped.
//   Halt: after a bad tag, bad length or bad trailer the block keeps accepting bytes
//   but discards them and emits nothing until the next reset.
//   Truncation: final_byte inside a record emits a truncated status and restarts
//   parsing at a record start without halting.
module grib1_record_header_parser_unit #(
    parameter int HEADER_BYTES = grib1_rhp_pkg::HEADER_BYTES_DEF,
    parameter int COUNTER_BITS = grib1_rhp_pkg::COUNTER_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    grib1_rhp_byte_if.sink     i_byte_if,
    grib1_rhp_result_if.source o_result_if
);
    import grib1_rhp_pkg::*;

    // Parser state
    logic [23:0]             r_pos, n_pos;
    logic [23:0]             r_rec_len, n_rec_len;
    logic [23:0]             r_sec_len, n_sec_len;
    logic [7:0]              r_hdr [HEADER_BYTES];
    logic [7:0]              n_hdr [HEADER_BYTES];
    logic [31:0]             r_trail, n_trail;
    logic [COUNTER_BITS-1:0] r_count, n_count;
    logic                    r_halted, n_halted;

    // Per-byte decode
    logic        accept, active;
    logic [7:0]  in_byte;
    logic [23:0] hdr_idx;
    logic        hdr_wr, tag_bad, len_bad, rec_end, trailer_ok;
    logic [23:0] len_shift, sec_shift;
    logic [7:0]  pds [PDS_USED];
    logic        emit, full;
    t_status     status;
    t_result     result;
    logic        skid_ready;

    assign accept  = i_byte_if.valid && i_byte_if.ready;
    assign active  = accept && !r_halted;
    assign in_byte = i_byte_if.data_byte;

    // Decode where this byte falls in the record
    always_comb begin
        n_trail    = {r_trail[23:0], in_byte};
        tag_bad    = (r_pos < POS_LEN_FIRST) && (in_byte != tag_byte(r_pos[1:0]));
        len_shift  = {r_rec_len[15:0], in_byte};
        len_bad    = (r_pos == POS_LEN_LAST) && (len_shift < MIN_RECORD);
        hdr_idx    = r_pos - POS_PDS;
        hdr_wr     = (r_pos >= POS_PDS) && (hdr_idx < 24'(HEADER_BYTES));
        sec_shift  = {r_sec_len[15:0], in_byte};
        rec_end    = (r_pos >= POS_EDITION) &&
                     (({1'b0, r_pos} + 25'd1) == {1'b0, r_rec_len});
        trailer_ok = (n_trail == TRAILER_WORD);
    end

    // Captured header with this byte bypassed in
    always_comb begin
        for (int k = 0; k < HEADER_BYTES; k++) begin
            n_hdr[k] = (hdr_wr && hdr_idx == 24'(k)) ? in_byte : r_hdr[k];
        end
        n_sec_len = (hdr_wr && hdr_idx < 24'd3) ? sec_shift : r_sec_len;
        // Bytes at or beyond the section length read as zero
        for (int k = 0; k < PDS_USED; k++) begin
            pds[k] = (24'(k) < n_sec_len) ? n_hdr[k] : 8'd0;
        end
    end

    // Pick the result status
    always_comb begin
        emit   = 1'b0;
        full   = 1'b0;
        status = ST_OK;
        if (active) begin
            if (tag_bad) begin
                emit   = 1'b1;
                status = ST_BAD_TAG;
            end else if (len_bad) begin
                emit   = 1'b1;
                status = ST_BAD_LENGTH;
            end else if (rec_end) begin
                emit   = 1'b1;
                full   = 1'b1;
                status = trailer_ok ? ST_OK : ST_BAD_TRAILER;
            end else if (i_byte_if.final_byte) begin
                emit   = 1'b1;
                status = ST_TRUNCATED;
            end
        end
    end

    // Assemble the result transaction
    always_comb begin
        result               = '0;
        result.record_number = 16'(r_count);
        result.status        = status;
        if (full) begin
            result.year_of_century = pds[12];
            result.month_value     = pds[13];
            result.day_value       = pds[14];
            result.hour_value      = pds[15];
            result.minute_value    = pds[16];
            result.grid_number     = pds[6];
            result.field_number    = pds[8];
            result.offset_seconds  = forecast_offset(pds[17], pds[18], pds[19], pds[20]);
            result.level_type      = pds[9];
            result.level_value     = {pds[10], pds[11]};
        end
    end

    // Advance parser state for an accepted byte
    always_comb begin
        n_pos     = r_pos;
        n_rec_len = r_rec_len;
        n_count   = r_count;
        n_halted  = r_halted;
        if (active) begin
            if (tag_bad || len_bad) begin
                n_halted = 1'b1;
            end else if (rec_end) begin
                n_count   = r_count + 1'b1;
                n_pos     = '0;
                n_rec_len = '0;
                n_halted  = !trailer_ok;
            end else if (i_byte_if.final_byte) begin
                n_pos     = '0;
                n_rec_len = '0;
            end else begin
                n_pos = r_pos + 24'd1;
                if (r_pos >= POS_LEN_FIRST && r_pos <= POS_LEN_LAST) begin
                    n_rec_len = len_shift;
                end
            end
        end
    end

    // Register parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_rec_len <= '0;
            r_sec_len <= '0;
            r_trail   <= '0;
            r_count   <= '0;
            r_halted  <= 1'b0;
            for (int k = 0; k < HEADER_BYTES; k++) begin
                r_hdr[k] <= '0;
            end
        end else begin
            r_pos     <= n_pos;
            r_rec_len <= n_rec_len;
            r_count   <= n_count;
            r_halted  <= n_halted;
            if (active) begin
                r_trail <= n_trail;
            end
            // Clear record capture at record start, else take the bypassed copy
            if (active && !tag_bad && !len_bad &&
                (rec_end || i_byte_if.final_byte)) begin
                r_sec_len <= '0;
                for (int k = 0; k < HEADER_BYTES; k++) begin
                    r_hdr[k] <= '0;
                end
            end else if (active && !tag_bad && !len_bad) begin
                r_sec_len <= n_sec_len;
                for (int k = 0; k < HEADER_BYTES; k++) begin
                    r_hdr[k] <= n_hdr[k];
                end
            end
        end
    end

    grib1_rhp_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (emit),
        .i_result    (result),
        .o_ready     (skid_ready),
        .o_result_if (o_result_if)
    );

    assign i_byte_if.ready = skid_ready;

    // Once halted, stay halted until reset
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    // A record end or truncation restarts at the first byte of a record
    a_restart_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (status == ST_OK || status == ST_BAD_TRAILER || status == ST_TRUNCATED))
        |=> (r_pos == '0 && r_sec_len == '0))
        else $error("record state not cleared at record start");

    // The record counter moves only on a completed record
    a_count_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit && full) |=> $stable(r_count))
        else $error("record counter changed without a record end");

endmodule
